// ===== hw/rtl/lps_pkg.sv =====
package lps_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int RESP_BITS_DEF  = 24;

  // Configuration registers
  localparam int THR_BITS       = 24;
  localparam int CFG_DATA_BITS  = 24;
  localparam int CFG_INDEX_BITS = 2;
  localparam int DIM_BITS       = 12;
  localparam int MIN_DIM        = 3;
  localparam int MAX_HEIGHT     = 2048;
  localparam int WIDTH_RESET    = 640;
  localparam int HEIGHT_RESET   = 480;

  localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd2;

  // Raster coordinates
  localparam int ROW_BITS   = 11;
  localparam int COORD_BITS = 11;

  // Result queue
  localparam int OUT_DEPTH      = 3;
  localparam int OUT_PTR_BITS   = 2;
  localparam int OUT_LEVEL_BITS = 2;

  // Position of the pixel that the current transaction decides
  typedef struct packed {
    logic                  decided;   // accepted pixel lies below row 0
    logic                  interior;  // not on a border: tests apply
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } lps_pos_t;

  typedef struct packed {
    logic                  out_valid;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  horizontal_peak;
    logic                  vertical_peak;
    logic                  line_flag;
  } lps_result_t;

endpackage

// ===== hw/rtl/lps_raster.sv =====
module lps_raster import lps_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  logic                              frame_start,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]    width_eff,
  input  logic [DIM_BITS-1:0]               height_eff,
  output logic [$clog2(MAX_WIDTH)-1:0]      col,
  output logic [$clog2(MAX_WIDTH)-1:0]      col_right,
  output lps_pos_t                          pos
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);

  logic [AW-1:0]       col_cnt;
  logic [ROW_BITS-1:0] row_cnt;
  logic [AW-1:0]       col_cnt_next;
  logic [ROW_BITS-1:0] row_cnt_next;

  logic [AW-1:0]       col_a;
  logic [ROW_BITS-1:0] row_a;
  logic                wrap_a;
  logic [DIM_BITS-1:0] row_b;
  logic [ROW_BITS-1:0] row_c;
  logic [WW-1:0]       col_inc;
  logic                end_row;
  logic [DIM_BITS-1:0] row_inc;

  // Position of the incoming pixel: frame start, then wrap of stale counters
  always_comb begin
    col_a  = frame_start ? '0 : col_cnt;
    row_a  = frame_start ? '0 : row_cnt;
    wrap_a = (WW'(col_a) >= width_eff);
    col    = wrap_a ? '0 : col_a;
    row_b  = wrap_a ? ({1'b0, row_a} + DIM_BITS'(1)) : {1'b0, row_a};
    row_c  = (row_b >= height_eff) ? '0 : row_b[ROW_BITS-1:0];
  end

  // Advance to the next pixel
  always_comb begin
    col_inc   = WW'(col) + WW'(1);
    end_row   = (col_inc >= width_eff);
    row_inc   = {1'b0, row_c} + DIM_BITS'(1);
    col_right = col_inc[AW-1:0];
    if (end_row) begin
      col_cnt_next = '0;
      row_cnt_next = (row_inc >= height_eff) ? '0 : row_inc[ROW_BITS-1:0];
    end else begin
      col_cnt_next = col_inc[AW-1:0];
      row_cnt_next = row_c;
    end
  end

  // Decided pixel sits one row above, same column
  always_comb begin
    pos.decided  = (row_c != '0);
    pos.interior = (col != '0) && !end_row && (row_c >= ROW_BITS'(2));
    pos.x        = COORD_BITS'(col);
    pos.y        = COORD_BITS'(row_c - ROW_BITS'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (accept) begin
      col_cnt <= col_cnt_next;
      row_cnt <= row_cnt_next;
    end
  end

  // Counters stay inside the frame size they were advanced with
  assert property (@(posedge clk) disable iff (rst)
    accept |=> WW'(col_cnt) < $past(width_eff))
    else $error("column counter left the row");

  assert property (@(posedge clk) disable iff (rst)
    accept |=> {1'b0, row_cnt} < $past(height_eff))
    else $error("row counter left the frame");

endmodule

// ===== hw/rtl/lps_hor_buf.sv =====
module lps_hor_buf import lps_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int RESP_BITS = RESP_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [$clog2(MAX_WIDTH)-1:0]  addr,
  input  logic [$clog2(MAX_WIDTH)-1:0]  addr_right,
  input  logic signed [RESP_BITS-1:0]   wr_data,
  output logic signed [RESP_BITS-1:0]   center,
  output logic signed [RESP_BITS-1:0]   right
);

  // Horizontal responses of the previous row; read-first, so the column
  // being overwritten still returns its previous-row value
  logic [RESP_BITS-1:0] mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (we) begin
      center    <= mem[addr];
      right     <= mem[addr_right];
      mem[addr] <= wr_data;
    end
  end

endmodule

// ===== hw/rtl/lps_ver_buf.sv =====
module lps_ver_buf import lps_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int RESP_BITS = RESP_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [$clog2(MAX_WIDTH)-1:0]  addr,
  input  logic signed [RESP_BITS-1:0]   cur_in,
  output logic signed [RESP_BITS-1:0]   above,
  output logic signed [RESP_BITS-1:0]   above2,
  output logic signed [RESP_BITS-1:0]   cur
);

  localparam int AW = $clog2(MAX_WIDTH);

  // Entry: {previous row, row before that}
  logic [2*RESP_BITS-1:0] mem [MAX_WIDTH];
  logic [2*RESP_BITS-1:0] rd_q;
  logic [2*RESP_BITS-1:0] fwd_q;
  logic [2*RESP_BITS-1:0] old_entry;
  logic [2*RESP_BITS-1:0] new_entry;
  logic                   fwd_hit;
  logic                   s1_valid;
  logic [AW-1:0]          s1_addr;

  // Read stage
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_q    <= mem[addr];
      s1_addr <= addr;
      cur     <= cur_in;
    end
  end

  // Old entry, with the write of the transaction just ahead forwarded
  always_comb begin
    old_entry = fwd_hit ? fwd_q : rd_q;
    above     = old_entry[2*RESP_BITS-1:RESP_BITS];
    above2    = old_entry[RESP_BITS-1:0];
    new_entry = {cur, old_entry[2*RESP_BITS-1:RESP_BITS]};
  end

  // Write-back stage: shift the column down one row
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      mem[s1_addr] <= new_entry;
    end
    fwd_q <= new_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      s1_valid <= accept;
      fwd_hit  <= accept && s1_valid && (addr == s1_addr);
    end
  end

endmodule

// ===== hw/rtl/lps_out_fifo.sv =====
module lps_out_fifo import lps_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  lps_result_t               push_data,
  input  logic                      pop,
  output logic                      valid,
  output lps_result_t               head,
  output logic [OUT_LEVEL_BITS-1:0] level
);

  lps_result_t             entries [OUT_DEPTH];
  logic [OUT_PTR_BITS-1:0] wr_ptr;
  logic [OUT_PTR_BITS-1:0] rd_ptr;

  function automatic logic [OUT_PTR_BITS-1:0] ptr_inc(input logic [OUT_PTR_BITS-1:0] p);
    ptr_inc = (p == OUT_PTR_BITS'(OUT_DEPTH - 1)) ? '0 : p + OUT_PTR_BITS'(1);
  endfunction

  assign valid = (level != '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        level <= level + OUT_LEVEL_BITS'(1);
      end else if (pop && !push) begin
        level <= level - OUT_LEVEL_BITS'(1);
      end
    end
  end

  // Intake is throttled upstream, so a push never finds the queue full
  assert property (@(posedge clk) disable iff (rst)
    push |-> level < OUT_LEVEL_BITS'(OUT_DEPTH))
    else $error("result queue overflow");

  assert property (@(posedge clk) disable iff (rst)
    level == '0 |-> wr_ptr == rd_ptr)
    else $error("result queue pointers out of step");

endmodule

// ===== hw/rtl/line_peak_suppressor.sv =====
// Streaming 3-tap non-maximum suppression on a raster of paired
// horizontal/vertical filter responses. Every accepted pixel yields exactly
// one result transaction: the decision for the pixel in the same column one
// row above (out_valid low while the input is in row 0, border pixels carry
// out_valid high with all flags low, the last row is never decided). Pixels
// are taken at one per clock while in_ready is high; each result is held in
// the decision stage and then queued before it is shown. The rate is set
// by the vertical line buffer, a one-read one-write read-modify-write memory
// with a forwarding path from the write-back stage; the horizontal line
// buffer is written at accept and read at two columns.
// A three-entry result queue absorbs backpressure, so intake only stops when
// results are not being taken. Line buffers power up unwritten and need no
// clearing pass; only interior decisions read them, and those columns have
// been written unless the width grew. Sizes are clamped to [3, MAX_WIDTH] and
// [3, 2048]; write configuration only while the block is idle.
module line_peak_suppressor import lps_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int RESP_BITS = RESP_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [CFG_DATA_BITS-1:0]    cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [RESP_BITS-1:0] hor_response,
  input  logic signed [RESP_BITS-1:0] ver_response,
  input  logic                        frame_start,
  output logic                        res_valid,
  input  logic                        res_ready,
  output logic                        out_valid,
  output logic [COORD_BITS-1:0]       pixel_x,
  output logic [COORD_BITS-1:0]       pixel_y,
  output logic                        horizontal_peak,
  output logic                        vertical_peak,
  output logic                        line_flag
);

  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CW   = (WW > DIM_BITS) ? WW : DIM_BITS;
  localparam int CMPW = (RESP_BITS > THR_BITS) ? RESP_BITS : THR_BITS;
  localparam int WIDTH_RST = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

  logic signed [THR_BITS-1:0] threshold;
  logic [WW-1:0]              width_eff;
  logic [DIM_BITS-1:0]        height_eff;
  logic [DIM_BITS-1:0]        cfg_dim;
  logic [WW-1:0]              width_clamp;
  logic [DIM_BITS-1:0]        height_clamp;

  logic                       accept;
  logic [AW-1:0]              col;
  logic [AW-1:0]              col_right;
  lps_pos_t                   pos;

  logic                       s1_valid;
  lps_pos_t                   s1_pos;
  logic signed [RESP_BITS-1:0] hor_center;
  logic signed [RESP_BITS-1:0] hor_right;
  logic signed [RESP_BITS-1:0] hor_left;
  logic signed [RESP_BITS-1:0] ver_above;
  logic signed [RESP_BITS-1:0] ver_above2;
  logic signed [RESP_BITS-1:0] ver_cur;

  logic signed [CMPW-1:0]     thr_x;
  logic signed [CMPW-1:0]     hc_x;
  logic signed [CMPW-1:0]     hl_x;
  logic signed [CMPW-1:0]     hr_x;
  logic signed [CMPW-1:0]     vc_x;
  logic signed [CMPW-1:0]     vt_x;
  logic signed [CMPW-1:0]     vb_x;
  logic                       hp;
  logic                       vp;
  lps_result_t                result;
  lps_result_t                head;
  logic [OUT_LEVEL_BITS-1:0]  out_level;
  logic [OUT_LEVEL_BITS:0]    inflight;

  // Size clamping on configuration writes
  always_comb begin
    cfg_dim = cfg_data[DIM_BITS-1:0];
    if (cfg_dim < DIM_BITS'(MIN_DIM)) begin
      width_clamp = WW'(MIN_DIM);
    end else if (CW'(cfg_dim) > CW'(MAX_WIDTH)) begin
      width_clamp = WW'(MAX_WIDTH);
    end else begin
      width_clamp = WW'(cfg_dim);
    end
    if (cfg_dim < DIM_BITS'(MIN_DIM)) begin
      height_clamp = DIM_BITS'(MIN_DIM);
    end else if (cfg_dim > DIM_BITS'(MAX_HEIGHT)) begin
      height_clamp = DIM_BITS'(MAX_HEIGHT);
    end else begin
      height_clamp = cfg_dim;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold  <= '0;
      width_eff  <= WW'(WIDTH_RST);
      height_eff <= DIM_BITS'(HEIGHT_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD:    threshold  <= cfg_data[THR_BITS-1:0];
        REG_IMAGE_WIDTH:  width_eff  <= width_clamp;
        REG_IMAGE_HEIGHT: height_eff <= height_clamp;
        default: ;
      endcase
    end
  end

  // Intake: stop only when queue plus the stage in flight could overfill
  assign inflight = {1'b0, out_level} + (OUT_LEVEL_BITS+1)'(s1_valid);
  assign in_ready = (inflight < (OUT_LEVEL_BITS+1)'(OUT_DEPTH));
  assign accept   = in_valid && in_ready;

  lps_raster #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_raster (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .frame_start (frame_start),
    .width_eff   (width_eff),
    .height_eff  (height_eff),
    .col         (col),
    .col_right   (col_right),
    .pos         (pos)
  );

  lps_hor_buf #(
    .MAX_WIDTH (MAX_WIDTH),
    .RESP_BITS (RESP_BITS)
  ) u_hor_buf (
    .clk        (clk),
    .we         (accept),
    .addr       (col),
    .addr_right (col_right),
    .wr_data    (hor_response),
    .center     (hor_center),
    .right      (hor_right)
  );

  lps_ver_buf #(
    .MAX_WIDTH (MAX_WIDTH),
    .RESP_BITS (RESP_BITS)
  ) u_ver_buf (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .addr   (col),
    .cur_in (ver_response),
    .above  (ver_above),
    .above2 (ver_above2),
    .cur    (ver_cur)
  );

  // Decision stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pos <= pos;
    end
  end

  // Previous-row value one column to the left
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      hor_left <= hor_center;
    end
  end

  always_comb begin
    thr_x = CMPW'(threshold);
    hc_x  = CMPW'(hor_center);
    hl_x  = CMPW'(hor_left);
    hr_x  = CMPW'(hor_right);
    vc_x  = CMPW'(ver_above);
    vt_x  = CMPW'(ver_above2);
    vb_x  = CMPW'(ver_cur);
    hp    = s1_pos.interior && (hc_x > hl_x) && (hc_x > hr_x) && (hc_x > thr_x);
    vp    = s1_pos.interior && (vc_x > vt_x) && (vc_x > vb_x) && (vc_x > thr_x);
    result.out_valid       = s1_pos.decided;
    result.pixel_x         = s1_pos.decided ? s1_pos.x : '0;
    result.pixel_y         = s1_pos.decided ? s1_pos.y : '0;
    result.horizontal_peak = hp;
    result.vertical_peak   = vp;
    result.line_flag       = hp || vp;
  end

  lps_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_valid),
    .push_data (result),
    .pop       (res_valid && res_ready),
    .valid     (res_valid),
    .head      (head),
    .level     (out_level)
  );

  assign out_valid       = head.out_valid;
  assign pixel_x         = head.pixel_x;
  assign pixel_y         = head.pixel_y;
  assign horizontal_peak = head.horizontal_peak;
  assign vertical_peak   = head.vertical_peak;
  assign line_flag       = head.line_flag;

  // Every accepted pixel reaches the decision stage on the next clock
  assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted pixel lost before decision stage");

endmodule

// ===== tb/tb_line_peak_suppressor.sv =====
module tb_line_peak_suppressor;
  import lps_pkg::*;

  localparam int RESP_W      = RESP_BITS_DEF;
  localparam int CYCLE_LIMIT = 700000;
  localparam int RANDOM_ITEMS = 620;
  localparam int MAX_REPORTS = 10;

  localparam logic signed [RESP_W-1:0] RESP_MAX = {1'b0, {(RESP_W-1){1'b1}}};
  localparam logic signed [RESP_W-1:0] RESP_MIN = {1'b1, {(RESP_W-1){1'b0}}};

  // index past the last register, the block must ignore it
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

  typedef enum int {VAL_WIDE, VAL_NARROW, VAL_CORNER} val_mode_e;
  typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_LIGHT} rx_mode_e;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [RESP_W-1:0]  hor_response = '0;
  logic signed [RESP_W-1:0]  ver_response = '0;
  logic                      frame_start = 1'b0;
  logic                      res_valid;
  logic                      res_ready = 1'b0;
  logic                      out_valid;
  logic [COORD_BITS-1:0]     pixel_x;
  logic [COORD_BITS-1:0]     pixel_y;
  logic                      horizontal_peak;
  logic                      vertical_peak;
  logic                      line_flag;

  line_peak_suppressor dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .hor_response    (hor_response),
    .ver_response    (ver_response),
    .frame_start     (frame_start),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .out_valid       (out_valid),
    .pixel_x         (pixel_x),
    .pixel_y         (pixel_y),
    .horizontal_peak (horizontal_peak),
    .vertical_peak   (vertical_peak),
    .line_flag       (line_flag)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state: registers, line buffers and raster position
  logic signed [RESP_W-1:0] thr_reg = '0;
  logic [DIM_BITS-1:0]      width_reg = DIM_BITS'(WIDTH_RESET);
  logic [DIM_BITS-1:0]      height_reg = DIM_BITS'(HEIGHT_RESET);
  logic signed [RESP_W-1:0] hor_line [MAX_WIDTH_DEF];
  logic signed [RESP_W-1:0] ver_line [MAX_WIDTH_DEF];
  logic signed [RESP_W-1:0] ver_line_old [MAX_WIDTH_DEF];
  logic signed [RESP_W-1:0] hor_left = '0;
  int                       col_pos = 0;
  int                       row_pos = 0;

  lps_result_t decision_q [$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          stall_tick = 0;
  int          burst_left = 0;

  function automatic int eff_dim(logic [DIM_BITS-1:0] v, int hi);
    int d;
    d = int'(v);
    if (d < MIN_DIM) d = MIN_DIM;
    if (d > hi) d = hi;
    return d;
  endfunction

  function automatic logic signed [RESP_W-1:0] pick_resp(val_mode_e mode);
    int t;
    case (mode)
      VAL_NARROW: begin
        t = int'($urandom_range(8)) - 4;
        return t[RESP_W-1:0];
      end
      VAL_CORNER: begin
        case ($urandom_range(4))
          0: return RESP_MAX;
          1: return RESP_MIN;
          2: return '0;
          3: return '1;
          default: return RESP_W'($urandom);
        endcase
      end
      default: return RESP_W'($urandom);
    endcase
  endfunction

  // Decision for the pixel one row above the accepted one
  task automatic predict_pixel(input logic signed [RESP_W-1:0] hv,
                               input logic signed [RESP_W-1:0] vv, input logic fs);
    int                       w, h, c, r;
    logic                     hp, vp;
    logic signed [RESP_W-1:0] center, right, vc, vt;
    lps_result_t              res;
    w = eff_dim(width_reg, MAX_WIDTH_DEF);
    h = eff_dim(height_reg, MAX_HEIGHT);
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    // counters may lie past a size that shrank
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    c = col_pos;
    r = row_pos;
    hp = 1'b0;
    vp = 1'b0;
    res = '0;
    if (r != 0) begin
      if (c >= 1 && c + 1 < w && r >= 2) begin
        center = hor_line[c];
        right  = hor_line[c+1];
        vc     = ver_line[c];
        vt     = ver_line_old[c];
        hp = (center > hor_left) && (center > right) && (center > thr_reg);
        vp = (vc > vt) && (vc > vv) && (vc > thr_reg);
      end
      res.out_valid       = 1'b1;
      res.pixel_x         = COORD_BITS'(c);
      res.pixel_y         = COORD_BITS'(r - 1);
      res.horizontal_peak = hp;
      res.vertical_peak   = vp;
      res.line_flag       = hp | vp;
    end
    decision_q.push_back(res);
    // line buffer update
    hor_left        = hor_line[c];
    hor_line[c]     = hv;
    ver_line_old[c] = ver_line[c];
    ver_line[c]     = vv;
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  // Sender pacing: bursts with gaps, some long bursts with no gap at all
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 24);
    end
  endtask

  task automatic send_pixel(input logic signed [RESP_W-1:0] hv,
                            input logic signed [RESP_W-1:0] vv, input logic fs);
    in_valid     <= 1'b1;
    hor_response <= hv;
    ver_response <= vv;
    frame_start  <= fs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_pixel(hv, vv, fs);
    pace_sender();
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_THRESHOLD:    thr_reg = data[THR_BITS-1:0];
      REG_IMAGE_WIDTH:  width_reg = data[DIM_BITS-1:0];
      REG_IMAGE_HEIGHT: height_reg = data[DIM_BITS-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Size write with junk in the unused upper bits
  function automatic logic [CFG_DATA_BITS-1:0] dim_word(int d);
    return {(CFG_DATA_BITS-DIM_BITS)'($urandom), DIM_BITS'(d)};
  endfunction

  task automatic drain_results();
    in_valid <= 1'b0;
    while (decision_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Small frame with hand-picked values: ties, equal threshold, extremes
  task automatic test_directed_frame();
    logic signed [RESP_W-1:0] hor_seq [15];
    logic signed [RESP_W-1:0] ver_seq [15];
    int i;
    hor_seq = '{0, RESP_MIN, RESP_MAX, 1, -1,
                RESP_MIN, RESP_MAX, 0, 0, RESP_MAX,
                -1, 0, RESP_MAX, RESP_MIN, 5};
    ver_seq = '{0, 0, 5, RESP_MIN, RESP_MAX,
                0, RESP_MAX, 5, 1, RESP_MIN,
                RESP_MAX, RESP_MIN, 4, 0, -1};
    // a few pixels at the reset sizes, all in row 0
    for (i = 0; i < 3; i++) send_pixel(pick_resp(VAL_CORNER), pick_resp(VAL_CORNER), i == 0);
    drain_results();
    write_reg(REG_UNUSED, CFG_DATA_BITS'($urandom));
    write_reg(REG_THRESHOLD, CFG_DATA_BITS'(1));
    write_reg(REG_IMAGE_WIDTH, dim_word(5));
    write_reg(REG_IMAGE_HEIGHT, dim_word(3));
    for (i = 0; i < 15; i++) send_pixel(hor_seq[i], ver_seq[i], i == 0);
    // implicit wrap into the next frame, then a restart mid-row
    for (i = 0; i < 5; i++) send_pixel(pick_resp(VAL_CORNER), pick_resp(VAL_CORNER), i == 2);
    drain_results();
  endtask

  // Widest row: top width, first row only, leaves the counters far out
  task automatic test_widest_row();
    int i;
    write_reg(REG_THRESHOLD, CFG_DATA_BITS'($urandom));
    write_reg(REG_IMAGE_WIDTH, dim_word(MAX_WIDTH_DEF));
    write_reg(REG_IMAGE_HEIGHT, dim_word(3));
    for (i = 0; i < 120; i++)
      send_pixel(pick_resp(VAL_WIDE), pick_resp(VAL_NARROW), i == 0);
    drain_results();
  endtask

  // Clamped sizes: narrowest width, height above the top
  task automatic test_tallest_frame();
    int i;
    write_reg(REG_THRESHOLD, CFG_DATA_BITS'(-2));
    write_reg(REG_IMAGE_WIDTH, dim_word(0));
    write_reg(REG_IMAGE_HEIGHT, dim_word(4095));
    // counters from the wide frame wrap without a frame start
    for (i = 0; i < 3 * 40 + 9; i++)
      send_pixel(pick_resp(VAL_NARROW), pick_resp(VAL_NARROW), 1'b0);
    drain_results();
  endtask

  task automatic test_random_phases();
    int        sent, phase, n, i, old_w, d;
    logic      fs, grew;
    val_mode_e mode;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      old_w = eff_dim(width_reg, MAX_WIDTH_DEF);
      mode  = val_mode_e'($urandom_range(2));
      if (phase == 0) write_reg(REG_THRESHOLD, CFG_DATA_BITS'(RESP_MIN));
      else if (phase == 1) write_reg(REG_THRESHOLD, CFG_DATA_BITS'(RESP_MAX));
      else if ($urandom_range(1) == 0) begin
        if (mode == VAL_NARROW || $urandom_range(1) == 0)
          write_reg(REG_THRESHOLD, CFG_DATA_BITS'(int'($urandom_range(6)) - 3));
        else
          write_reg(REG_THRESHOLD, CFG_DATA_BITS'($urandom));
      end
      if ($urandom_range(1) == 0) begin
        d = ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(3, 10);
        write_reg(REG_IMAGE_WIDTH, dim_word(d));
      end
      if ($urandom_range(1) == 0) begin
        case ($urandom_range(15))
          0, 1:    d = $urandom_range(2);
          2:       d = 4095;
          default: d = $urandom_range(3, 6);
        endcase
        write_reg(REG_IMAGE_HEIGHT, dim_word(d));
      end
      if ($urandom_range(5) == 0) write_reg(REG_UNUSED, CFG_DATA_BITS'($urandom));
      // a wider row needs a fresh frame so every buffered column is written
      grew = eff_dim(width_reg, MAX_WIDTH_DEF) > old_w;
      n = $urandom_range(20, 120);
      for (i = 0; i < n; i++) begin
        if (i == 0) fs = grew || ($urandom_range(2) == 0);
        else fs = ($urandom_range(63) == 0);
        send_pixel(pick_resp(mode), pick_resp(mode), fs);
      end
      sent += n;
      phase++;
      drain_results();
    end
  endtask

  // Receiver stalls: open, coin flip, fixed duty, light
  always @(posedge clk) begin
    stall_tick++;
    case (rx_mode_e'((stall_tick / 300) % 4))
      RX_OPEN:     res_ready <= 1'b1;
      RX_COIN:     res_ready <= ($urandom_range(1) == 1);
      RX_PERIODIC: res_ready <= ((stall_tick % 7) >= 3);
      default:     res_ready <= ($urandom_range(4) != 0);
    endcase
  end

  // Result check against the oldest pending decision
  always @(posedge clk) begin : result_check
    lps_result_t want;
    if (!rst && res_valid && res_ready) begin
      if (decision_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result transaction at cycle %0d", cycle_count);
      end else begin
        want = decision_q.pop_front();
        if (out_valid !== want.out_valid || pixel_x !== want.pixel_x ||
            pixel_y !== want.pixel_y || horizontal_peak !== want.horizontal_peak ||
            vertical_peak !== want.vertical_peak || line_flag !== want.line_flag) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("cycle %0d exp v=%0b x=%0d y=%0d h=%0b vp=%0b l=%0b",
                     cycle_count, want.out_valid, want.pixel_x, want.pixel_y,
                     want.horizontal_peak, want.vertical_peak, want.line_flag,
                     " got v=%0b x=%0d y=%0d h=%0b vp=%0b l=%0b",
                     out_valid, pixel_x, pixel_y, horizontal_peak, vertical_peak,
                     line_flag);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_frame();
    test_widest_row();
    test_tallest_frame();
    test_random_phases();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/lps_pkg.sv
hw/rtl/lps_raster.sv
hw/rtl/lps_hor_buf.sv
hw/rtl/lps_ver_buf.sv
hw/rtl/lps_out_fifo.sv
hw/rtl/line_peak_suppressor.sv
tb/tb_line_peak_suppressor.sv
